// File: rtl/ptc_pkg.sv
// Package for the pixel tone and colour pipeline: command codes, register
// indexes, luma weights and default widths. No dependencies.
package ptc_pkg;

  localparam int FRACTION_BITS_DEF = 12;

  localparam int PIX_W        = 8;
  localparam int TABLE_DEPTH  = 256;
  localparam int CMD_W        = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int GAIN_W       = 16;
  localparam int CONTRAST_W   = 16;
  localparam int BRIGHT_W     = 9;
  localparam int AMOUNT_W     = 14;
  localparam int SAT_SCALE_W  = 13;
  localparam int Q12          = 12;
  localparam int LUMA_SHIFT   = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL  = 3'd0,
    CMD_CURVE  = 3'd1,
    CMD_MASTER = 3'd2,
    CMD_RED    = 3'd3,
    CMD_GREEN  = 3'd4,
    CMD_BLUE   = 3'd5
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_WB_GAINS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHADOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_SCALE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VIBRANCE   = 3'd6;

  // Rec. 601 luma weights in Q0.16, red, green, blue.
  localparam logic signed [17:0] LUMA_COEF [3] = '{18'sd19595, 18'sd38470, 18'sd7471};
  localparam logic signed [7:0]  LIFT_GAIN = 8'sd60;

endpackage

// File: rtl/ptc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (en) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ptc_tone.sv
// Tone section: contrast and brightness, luma, highlight and shadow lift,
// second luma and the operands of the saturation division. Uses ptc_pkg.
module ptc_tone import ptc_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_vld,
  input  logic [PIX_W-1:0]                  lvl [3],
  input  logic [PIX_W-1:0]                  in_alpha,
  input  logic [CONTRAST_W-1:0]             contrast,
  input  logic [BRIGHT_W-1:0]               bright,
  input  logic [AMOUNT_W-1:0]               highlight,
  input  logic [AMOUNT_W-1:0]               shadow,
  output logic                              out_vld,
  output logic [PIX_W-1:0]                  out_alpha,
  output logic signed [FRACTION_BITS+13:0]  out_c [3],
  output logic signed [FRACTION_BITS+13:0]  out_luma,
  output logic [2*FRACTION_BITS+14:0]       out_num,
  output logic [FRACTION_BITS+12:0]         out_den,
  output logic                              out_pos
);

  localparam int F   = FRACTION_BITS;
  localparam int C_W = F + 14;
  localparam int DW  = F + 13;
  localparam int LP_W = C_W + 18;
  localparam int LS_W = C_W + 20;
  localparam int UP  = (F >= Q12) ? F - Q12 : 0;
  localparam int DN  = (F >= Q12) ? 0 : Q12 - F;
  localparam logic [F:0] ONE = (F+1)'(1) << F;
  localparam logic signed [C_W-1:0] LUMA_BIG = C_W'(255) << F;
  // Exact reciprocal of 255 for dividends below 2^(F+8).
  localparam logic [F+8:0] LUMA_RCP = (F+9)'(((64'd1 << (F + 16)) + 64'd254) / 64'd255);

  // Lift gains, refreshed every cycle from the static registers.
  logic signed [19:0] hi60, sh60;
  always_ff @(posedge clk) begin
    hi60 <= $signed(highlight) * LIFT_GAIN;
    sh60 <= $signed(shadow) * LIFT_GAIN;
  end

  // Contrast slope scaled to F fraction bits.
  logic [CONTRAST_W+UP-1:0] cf_w;
  logic [CONTRAST_W+UP-1:0] cf_s;
  logic [F+3:0]             cf;
  assign cf_w = {{UP{1'b0}}, contrast} << UP;
  assign cf_s = cf_w >> DN;
  assign cf   = cf_s[F+3:0];

  logic signed [10:0]      midb;
  logic signed [C_W-1:0]   mid;
  assign midb = $signed({{2{bright[BRIGHT_W-1]}}, bright}) + 11'sd128;
  assign mid  = C_W'($signed({midb, {F{1'b0}}}));

  // Stage registers.
  logic                  v4, v5, v6, v7, v8, v9, v10, v11;
  logic [PIX_W-1:0]      a4, a5, a6, a7, a8, a9, a10, a11;
  logic signed [C_W-1:0] c4 [3], c5 [3], c6 [3], c7 [3], c8 [3], c9 [3], c10 [3], c11 [3];
  logic signed [LP_W-1:0] lp5 [3], lp11 [3];
  logic [F+7:0]          x6;
  logic                  big6, big7;
  logic [2*F+16:0]       prod7;
  logic [2*F+1:0]        sqh8, sqs8;
  logic signed [F+21:0]  dh9, ds9;
  logic signed [C_W-1:0] mx11, mn11;

  // Combinational values between stages.
  logic signed [9:0]     dlt [3];
  logic signed [F+14:0]  cp [3];
  logic signed [LS_W-1:0] lsum5, lsh5, lsum11, lsh11;
  logic signed [C_W-1:0] luma5, luma11;
  logic [F:0]            ln7, oln7;
  logic [F:0]            th8, ts8;
  logic signed [F+21:0]  dhs9, dss9;
  logic signed [C_W-1:0] mx10, mn10;
  logic signed [C_W:0]   span11;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dlt[k] = $signed({2'b00, lvl[k]}) - 10'sd128;
      cp[k]  = $signed({1'b0, cf}) * dlt[k];
    end
    lsum5 = LS_W'(lp5[0]) + LS_W'(lp5[1]) + LS_W'(lp5[2]);
    lsh5  = lsum5 >>> LUMA_SHIFT;
    luma5 = $signed(lsh5[C_W-1:0]);
    ln7   = big7 ? ONE : prod7[2*F+16:F+16];
    oln7  = ONE - ln7;
    th8   = sqh8[2*F:F];
    ts8   = sqs8[2*F:F];
    dhs9  = dh9 >>> Q12;
    dss9  = ds9 >>> Q12;
    mx10  = c10[0];
    mn10  = c10[0];
    for (int k = 1; k < 3; k++) begin
      if (c10[k] > mx10) mx10 = c10[k];
      if (c10[k] < mn10) mn10 = c10[k];
    end
    lsum11 = LS_W'(lp11[0]) + LS_W'(lp11[1]) + LS_W'(lp11[2]);
    lsh11  = lsum11 >>> LUMA_SHIFT;
    luma11 = $signed(lsh11[C_W-1:0]);
    span11 = $signed({mx11[C_W-1], mx11}) - $signed({mn11[C_W-1], mn11});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
      v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0; v11 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v4 <= in_vld; v5 <= v4; v6 <= v5; v7 <= v6;
      v8 <= v7; v9 <= v8; v10 <= v9; v11 <= v10;
      out_vld <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a4 <= in_alpha; a5 <= a4; a6 <= a5; a7 <= a6;
      a8 <= a7; a9 <= a8; a10 <= a9; a11 <= a10;
      out_alpha <= a11;
      for (int k = 0; k < 3; k++) begin
        c4[k]  <= $signed(cp[k][C_W-1:0]) + mid;
        lp5[k] <= c4[k] * LUMA_COEF[k];
        c5[k]  <= c4[k];
        c6[k]  <= c5[k];
        c7[k]  <= c6[k];
        c8[k]  <= c7[k];
        c9[k]  <= c8[k];
        c10[k] <= c9[k] + $signed(dhs9[C_W-1:0]) + $signed(dss9[C_W-1:0]);
        lp11[k] <= c10[k] * LUMA_COEF[k];
        c11[k] <= c10[k];
        out_c[k] <= c11[k];
      end
      // Normalised luma: zero when not positive, one at or above full scale.
      if (luma5 <= 0) begin
        x6 <= '0;
        big6 <= 1'b0;
      end else if (luma5 >= LUMA_BIG) begin
        x6 <= '0;
        big6 <= 1'b1;
      end else begin
        x6 <= luma5[F+7:0];
        big6 <= 1'b0;
      end
      prod7 <= x6 * LUMA_RCP;
      big7  <= big6;
      sqh8  <= ln7 * ln7;
      sqs8  <= oln7 * oln7;
      dh9   <= hi60 * $signed({1'b0, th8});
      ds9   <= sh60 * $signed({1'b0, ts8});
      mx11  <= mx10;
      mn11  <= mn10;
      out_luma <= luma11;
      out_num  <= {span11, {F{1'b0}}};
      out_pos  <= (mx11 > 0);
      out_den  <= (mx11 > 0) ? mx11[DW-1:0] : DW'(1);
    end
  end

endmodule

// File: rtl/ptc_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a side
// vector that travels alongside. Uses ptc_pkg only for the house import.
module ptc_divider import ptc_pkg::*; #(
  parameter int NUM_W  = 39,
  parameter int DEN_W  = 25,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [NUM_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld  [NUM_W];
  logic [DEN_W-1:0]  rem  [NUM_W];
  logic [NUM_W-1:0]  acc  [NUM_W];
  logic [DEN_W-1:0]  den  [NUM_W];
  logic [SIDE_W-1:0] side [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              p_vld;
    logic [DEN_W-1:0]  p_rem;
    logic [NUM_W-1:0]  p_acc;
    logic [DEN_W-1:0]  p_den;
    logic [SIDE_W-1:0] p_side;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (i == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_acc  = in_num;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld[i-1];
      assign p_rem  = rem[i-1];
      assign p_acc  = acc[i-1];
      assign p_den  = den[i-1];
      assign p_side = side[i-1];
    end

    assign trial = {p_rem, p_acc[NUM_W-1]};
    assign fits  = (trial >= {1'b0, p_den});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= fits ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
        acc[i]  <= {p_acc[NUM_W-2:0], fits};
        den[i]  <= p_den;
        side[i] <= p_side;
      end
    end
  end

  assign out_vld  = vld[NUM_W-1];
  assign out_quo  = acc[NUM_W-1];
  assign out_side = side[NUM_W-1];

endmodule

// File: rtl/ptc_chroma.sv
// Chroma section: saturation and vibrance scale about luma, rounding and
// clamping to 8 bits; holds the output register. Uses ptc_pkg.
module ptc_chroma import ptc_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_vld,
  input  logic [2*FRACTION_BITS+14:0]      sat,
  input  logic                             pos,
  input  logic [PIX_W-1:0]                 in_alpha,
  input  logic signed [FRACTION_BITS+13:0] in_luma,
  input  logic signed [FRACTION_BITS+13:0] in_c [3],
  input  logic [SAT_SCALE_W-1:0]           sat_scale,
  input  logic [AMOUNT_W-1:0]              vibrance,
  output logic                             out_vld,
  output logic [PIX_W-1:0]                 out_pix [3],
  output logic [PIX_W-1:0]                 out_alpha
);

  localparam int F    = FRACTION_BITS;
  localparam int C_W  = F + 14;
  localparam int QW   = 2 * F + 15;
  localparam int PV_W = QW + 2 + AMOUNT_W;
  localparam int SC_W = QW + 3;
  localparam int H    = (SC_W + 1) / 2;
  localparam int PW   = C_W + SC_W + 2;
  localparam int UP   = (F >= Q12) ? F - Q12 : 0;
  localparam int DN   = (F >= Q12) ? 0 : Q12 - F;
  localparam logic [QW-1:0] ONE = QW'(1) << F;
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  logic [SAT_SCALE_W+UP-1:0] ss_w, ss_s;
  logic [F:0]                satq;
  assign ss_w = {{UP{1'b0}}, sat_scale} << UP;
  assign ss_s = ss_w >> DN;
  assign satq = ss_s[F:0];

  logic                  va, vb, vc, vd;
  logic [PIX_W-1:0]      aa, ab, ac, ad;
  logic signed [C_W-1:0] la, lb, lc, ld;
  logic signed [C_W-1:0] ca [3];
  logic signed [PV_W-1:0] pva;
  logic signed [SC_W-1:0] scb;
  logic signed [C_W:0]   dfb [3];
  logic signed [C_W+H+1:0] ploc [3];
  logic signed [C_W+SC_W-H:0] phic [3];
  logic signed [PW-1:0]  vd_v [3];

  logic [QW-1:0]          satv;
  logic signed [QW+1:0]   oms;
  logic signed [PV_W-1:0] pvs;
  logic signed [PW-1:0]   full [3];
  logic signed [PW-1:0]   fsh [3];
  logic [PW-1:0]          vr [3];

  always_comb begin
    satv = pos ? sat : '0;
    oms  = $signed({2'b00, ONE}) - $signed({2'b00, satv});
    pvs  = pva >>> Q12;
    for (int k = 0; k < 3; k++) begin
      full[k] = (PW'(phic[k]) <<< H) + PW'(ploc[k]);
      fsh[k]  = full[k] >>> F;
      vr[k]   = vd_v[k] + HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      va <= in_vld; vb <= va; vc <= vb; vd <= vc;
      out_vld <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa <= in_alpha; ab <= aa; ac <= ab; ad <= ac;
      out_alpha <= ad;
      la <= in_luma; lb <= la; lc <= lb; ld <= lc;
      pva <= $signed(vibrance) * oms;
      scb <= SC_W'($signed({1'b0, satq})) + $signed(pvs[SC_W-1:0]);
      for (int k = 0; k < 3; k++) begin
        ca[k]   <= in_c[k];
        dfb[k]  <= $signed({ca[k][C_W-1], ca[k]}) - $signed({la[C_W-1], la});
        ploc[k] <= dfb[k] * $signed({1'b0, scb[H-1:0]});
        phic[k] <= dfb[k] * $signed(scb[SC_W-1:H]);
        vd_v[k] <= PW'(lc) + fsh[k];
        // Negative values round to zero or below and clamp to zero.
        if (vd_v[k][PW-1]) begin
          out_pix[k] <= '0;
        end else if (|vr[k][PW-1:F+8]) begin
          out_pix[k] <= '1;
        end else begin
          out_pix[k] <= vr[k][F+7:F];
        end
      end
    end
  end

endmodule

// File: rtl/pixel_tone_color_pipeline.sv
// Top level of the pixel tone and colour pipeline: stream ports, register
// file, lookup tables and the chain of tone, divider and chroma sections.
// Uses ptc_pkg, ptc_ram, ptc_tone, ptc_divider and ptc_chroma.
//
// Usage. Every transaction on the input stream carries a command in tuser.
// A pixel command brings an RGBA pixel; the five table commands write one
// byte into the curve, master levels, or red, green or blue levels table at
// table_index. Table writes produce no output transaction; each pixel
// produces exactly one, in input order. Tables hold no reset value, so every
// entry a pixel can reach must be written first. The seven adjustment
// registers are written through the plain write port; the user must write
// them only while the stream is quiet, as the block does not enforce it.
// They come out of reset at unity gains, unity contrast, unity saturation
// and zero offsets. The time from input acceptance to output valid is set
// mostly by the divider for pixel saturation, which resolves one quotient
// bit per stage. Throughput is one pixel per cycle while the output is
// not held. All stages move together: when the output register holds a
// transaction the receiver has not taken, the whole pipeline holds and
// s_axis_tready falls, so nothing is dropped or repeated. Reset empties the
// pipeline and restores the registers; table contents are left as they are.
module pixel_tone_color_pipeline import ptc_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // table_index[7:0], table_value[15:8], red_in[23:16], green_in[31:24],
  // blue_in[39:32], alpha_in[47:40]
  input  logic [47:0]           s_axis_tdata,
  // command[2:0]
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24]
  output logic [31:0]           m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int F      = FRACTION_BITS;
  localparam int C_W    = F + 14;
  localparam int QW     = 2 * F + 15;
  localparam int DW     = F + 13;
  localparam int SIDE_W = 1 + PIX_W + 4 * C_W;
  localparam int AW     = $clog2(TABLE_DEPTH);

  // Adjustment registers.
  logic [3*GAIN_W-1:0]     wb_gains;
  logic [CONTRAST_W-1:0]   contrast;
  logic [BRIGHT_W-1:0]     bright;
  logic [AMOUNT_W-1:0]     highlight;
  logic [AMOUNT_W-1:0]     shadow;
  logic [SAT_SCALE_W-1:0]  sat_scale;
  logic [AMOUNT_W-1:0]     vibrance;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_gains  <= 48'h1000_1000_1000;
      contrast  <= 16'h1000;
      bright    <= '0;
      highlight <= '0;
      shadow    <= '0;
      sat_scale <= 13'h1000;
      vibrance  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WB_GAINS:   wb_gains  <= cfg_data;
        CFG_CONTRAST:   contrast  <= cfg_data[CONTRAST_W-1:0];
        CFG_BRIGHTNESS: bright    <= cfg_data[BRIGHT_W-1:0];
        CFG_HIGHLIGHT:  highlight <= cfg_data[AMOUNT_W-1:0];
        CFG_SHADOW:     shadow    <= cfg_data[AMOUNT_W-1:0];
        CFG_SAT_SCALE:  sat_scale <= cfg_data[SAT_SCALE_W-1:0];
        CFG_VIBRANCE:   vibrance  <= cfg_data[AMOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // One shared advance for every stage; the output register frees it.
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  cmd_t             in_cmd;
  logic [PIX_W-1:0] in_px [3];
  assign in_cmd   = cmd_t'(s_axis_tuser);
  assign in_px[0] = s_axis_tdata[23:16];
  assign in_px[1] = s_axis_tdata[31:24];
  assign in_px[2] = s_axis_tdata[39:32];

  // White balance: truncate the Q4.12 product and clamp to a table address.
  logic [PIX_W+GAIN_W-1:0] wb_prod [3];
  logic [AW-1:0]           curve_addr [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wb_prod[k]    = in_px[k] * wb_gains[GAIN_W*k +: GAIN_W];
      curve_addr[k] = (|wb_prod[k][PIX_W+GAIN_W-1:Q12+PIX_W]) ? '1 : wb_prod[k][Q12+PIX_W-1:Q12];
    end
  end

  // Table stages. Each table is written as its command passes the stage
  // where pixels read that table, so reads and writes keep stream order.
  logic             p1_vld, p2_vld, p3_vld;
  cmd_t             p1_cmd, p2_cmd, p3_cmd;
  logic [AW-1:0]    p1_idx, p2_idx;
  logic [PIX_W-1:0] p1_val, p2_val;
  logic [PIX_W-1:0] p1_alpha, p2_alpha, p3_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= s_axis_tvalid;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_cmd   <= in_cmd;
      p1_idx   <= s_axis_tdata[7:0];
      p1_val   <= s_axis_tdata[15:8];
      p1_alpha <= s_axis_tdata[47:40];
      p2_cmd   <= p1_cmd;
      p2_idx   <= p1_idx;
      p2_val   <= p1_val;
      p2_alpha <= p1_alpha;
      p3_cmd   <= p2_cmd;
      p3_alpha <= p2_alpha;
    end
  end

  logic [PIX_W-1:0] curve_q [3];
  logic [PIX_W-1:0] master_q [3];
  logic [PIX_W-1:0] level_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    localparam cmd_t LCMD = (k == 0) ? CMD_RED : ((k == 1) ? CMD_GREEN : CMD_BLUE);

    ptc_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_DEPTH)) u_curve (
      .clk   (clk),
      .en    (en),
      .we    (s_axis_tvalid && en && in_cmd == CMD_CURVE),
      .waddr (s_axis_tdata[7:0]),
      .wdata (s_axis_tdata[15:8]),
      .raddr (curve_addr[k]),
      .rdata (curve_q[k])
    );

    ptc_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_DEPTH)) u_master (
      .clk   (clk),
      .en    (en),
      .we    (p1_vld && en && p1_cmd == CMD_MASTER),
      .waddr (p1_idx),
      .wdata (p1_val),
      .raddr (curve_q[k]),
      .rdata (master_q[k])
    );

    ptc_ram #(.WIDTH(PIX_W), .DEPTH(TABLE_DEPTH)) u_level (
      .clk   (clk),
      .en    (en),
      .we    (p2_vld && en && p2_cmd == LCMD),
      .waddr (p2_idx),
      .wdata (p2_val),
      .raddr (master_q[k]),
      .rdata (level_q[k])
    );
  end

  // Tone section.
  logic                  t_vld, t_pos;
  logic [PIX_W-1:0]      t_alpha;
  logic signed [C_W-1:0] t_c [3];
  logic signed [C_W-1:0] t_luma;
  logic [QW-1:0]         t_num;
  logic [DW-1:0]         t_den;

  ptc_tone #(.FRACTION_BITS(F)) u_tone (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (p3_vld && p3_cmd == CMD_PIXEL),
    .lvl       (level_q),
    .in_alpha  (p3_alpha),
    .contrast  (contrast),
    .bright    (bright),
    .highlight (highlight),
    .shadow    (shadow),
    .out_vld   (t_vld),
    .out_alpha (t_alpha),
    .out_c     (t_c),
    .out_luma  (t_luma),
    .out_num   (t_num),
    .out_den   (t_den),
    .out_pos   (t_pos)
  );

  // Saturation division, with the pixel carried alongside.
  logic              d_vld;
  logic [QW-1:0]     d_quo;
  logic [SIDE_W-1:0] d_side;

  ptc_divider #(.NUM_W(QW), .DEN_W(DW), .SIDE_W(SIDE_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (t_vld),
    .in_num   (t_num),
    .in_den   (t_den),
    .in_side  ({t_pos, t_alpha, t_luma, t_c[2], t_c[1], t_c[0]}),
    .out_vld  (d_vld),
    .out_quo  (d_quo),
    .out_side (d_side)
  );

  logic signed [C_W-1:0] d_c [3];
  assign d_c[0] = $signed(d_side[C_W-1:0]);
  assign d_c[1] = $signed(d_side[2*C_W-1:C_W]);
  assign d_c[2] = $signed(d_side[3*C_W-1:2*C_W]);

  // Chroma section and output register.
  logic [PIX_W-1:0] o_pix [3];
  logic [PIX_W-1:0] o_alpha;

  ptc_chroma #(.FRACTION_BITS(F)) u_chroma (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (d_vld),
    .sat       (d_quo),
    .pos       (d_side[SIDE_W-1]),
    .in_alpha  (d_side[SIDE_W-2:4*C_W]),
    .in_luma   ($signed(d_side[4*C_W-1:3*C_W])),
    .in_c      (d_c),
    .sat_scale (sat_scale),
    .vibrance  (vibrance),
    .out_vld   (m_axis_tvalid),
    .out_pix   (o_pix),
    .out_alpha (o_alpha)
  );

  assign m_axis_tdata = {o_alpha, o_pix[2], o_pix[1], o_pix[0]};

`ifndef SYNTHESIS
  // The pipeline is empty on the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid && !p1_vld)
    else $error("pipeline not empty after reset");

  // A stalled front stage keeps its transaction and its command.
  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (p1_vld && !en) |=> (p1_vld && $stable(p1_cmd) && $stable(p1_idx)))
    else $error("front stage lost a transaction during a stall");

  // A table write never enters the arithmetic chain.
  a_write_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (en && p3_vld && p3_cmd != CMD_PIXEL) |=> !u_tone.v4)
    else $error("table write entered the pixel path");
`endif

endmodule
